>>> src/cbm_pkg.sv
package cbm_pkg;

  // fixed geometry
  localparam int BANK_COUNT   = 64;
  localparam int BANK_BYTES   = 8192;
  localparam int RAM_BYTES    = 256;
  localparam int BANK_W       = 6;
  localparam int BANK_ENTRIES = 2 ** BANK_W;
  localparam int OFFSET_W     = $clog2(BANK_BYTES);
  localparam int RAM_AW       = $clog2(RAM_BYTES);
  localparam int ROM_ADDR_W   = 19;
  localparam int MODE_W       = 4;

  // register masks and reset values
  localparam logic [7:0] BANK_MASK  = 8'h3f;
  localparam logic [7:0] MODE_MASK  = 8'h87;
  localparam logic [7:0] RAM_FILL   = 8'hff;
  localparam int         MODE_SEL_BIT = 1;

  // bus access codes
  typedef enum logic [2:0] {
    CMD_ROML_RD = 3'd0,
    CMD_ROMH_RD = 3'd1,
    CMD_IO1_RD  = 3'd2,
    CMD_IO1_WR  = 3'd3,
    CMD_IO2_RD  = 3'd4,
    CMD_IO2_WR  = 3'd5
  } cmd_e;

  // flash chip select codes
  typedef enum logic [1:0] {
    CHIP_NONE = 2'd0,
    CHIP_LO   = 2'd1,
    CHIP_HI   = 2'd2
  } chip_e;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [OFFSET_W-1:0] offset;
    logic [7:0]          write_data;
    logic [7:0]          sys_ram_data;
    logic [7:0]          basic_rom_data;
    logic [7:0]          open_bus_data;
    logic                lo_ram_line;
    logic                hi_ram_line;
  } req_t;

  typedef struct packed {
    logic [7:0]            data_out;
    logic [1:0]            rom_chip;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic                  exrom_n;
    logic                  game_n;
    logic                  led_on;
  } rsp_t;

  // mapper register state seen by the decode logic
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [MODE_W-1:0] mode;
    logic              exrom_n;
    logic              game_n;
  } ctrl_t;

  typedef logic [BANK_W-1:0] bank_tbl_t [BANK_ENTRIES];

  // bank register folded onto the populated bank count
  function automatic bank_tbl_t build_bank_tbl();
    bank_tbl_t t;
    for (int i = 0; i < BANK_ENTRIES; i++) begin
      t[i] = BANK_W'(i % BANK_COUNT);
    end
    return t;
  endfunction

  localparam bank_tbl_t BANK_TBL = build_bank_tbl();

endpackage

>>> src/cbm_req_if.sv
interface cbm_req_if;
  logic               valid;
  logic               ready;
  cbm_pkg::req_t      data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/cbm_rsp_if.sv
interface cbm_rsp_if;
  logic               valid;
  logic               ready;
  cbm_pkg::rsp_t      data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/cartridge_bank_mode_mapper_top.sv
// Banked ROM cartridge mapper. Each accepted beat is one bus access (ROML/ROMH
// read, IO1 read/write, IO2 read/write) and yields exactly one result beat:
// a flash chip select with a 19-bit flat address, or a pass-through byte, plus
// the /EXROM, /GAME and LED levels after the access. A new beat is taken every
// cycle unless the consumer stalls with both stages full; a result beat passes
// through the input stage with the cartridge RAM read port and then the output
// register. A stalled consumer holds the output register and then the input
// stage, so input stalls only while both are full. Register and RAM writes take
// effect at the accept edge, in beat order. The boot jumper is sampled at mode
// writes only; change it while the block is idle. The 256-byte cartridge RAM
// needs no clearing pass: unwritten bytes read as 0xff from reset on.
module cartridge_bank_mode_mapper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  cbm_req_if.sink    req_i,
  cbm_rsp_if.source  rsp_o
);
  import cbm_pkg::*;

  logic   acc;
  logic   out_free;
  logic   s1_adv;
  logic   s1_vld_q;
  req_t   s1_q;
  logic   out_vld_q;
  rsp_t   out_q;
  rsp_t   rsp_d;
  ctrl_t  ctrl;
  logic [7:0] ram_rd;

  // handshake: a beat enters when the input stage is empty or moving on
  assign out_free    = !out_vld_q || rsp_o.ready;
  assign s1_adv      = s1_vld_q && out_free;
  assign req_i.ready = !s1_vld_q || out_free;
  assign acc         = req_i.valid && req_i.ready;

  // mapper registers
  cbm_ctrl_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .req_i       (req_i.data),
    .ctrl_o      (ctrl)
  );

  // cartridge ram on the io2 window
  cbm_cart_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .cmd_i   (req_i.data.cmd),
    .addr_i  (req_i.data.offset[RAM_AW-1:0]),
    .wdata_i (req_i.data.write_data),
    .rdata_o (ram_rd)
  );

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= req_i.data;
    end
  end

  cbm_decode u_dec (
    .req_i    (s1_q),
    .ctrl_i   (ctrl),
    .ram_rd_i (ram_rd),
    .rsp_o    (rsp_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  // a selected chip never carries a data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.rom_chip != CHIP_NONE) |-> out_q.data_out == '0)
    else $error("data byte driven with a chip selected");

  // no address without a chip select
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.rom_chip == CHIP_NONE) |-> out_q.rom_addr == '0)
    else $error("flash address without chip select");

  // a held input stage is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !out_free |-> !acc)
    else $error("beat accepted over a stalled input stage");

endmodule

>>> src/cbm_ctrl_regs.sv
module cbm_ctrl_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          acc_i,
  input  cbm_pkg::req_t req_i,
  output cbm_pkg::ctrl_t ctrl_o
);
  import cbm_pkg::*;

  logic              jumper_q;
  logic [BANK_W-1:0] bank_q, bank_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              exrom_q, exrom_d;
  logic              game_q, game_d;
  logic [7:0]        mode_bits;
  logic              io1_wr;

  // boot jumper
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jumper_q <= 1'b1;
    end else if (cfg_we_i) begin
      jumper_q <= cfg_wdata_i;
    end
  end

  // io1 writes land on the bank or the mode register
  assign io1_wr    = acc_i && (req_i.cmd == CMD_IO1_WR);
  assign mode_bits = req_i.write_data & MODE_MASK;

  always_comb begin
    bank_d  = bank_q;
    mode_d  = mode_q;
    exrom_d = exrom_q;
    game_d  = game_q;
    if (io1_wr) begin
      if (!req_i.offset[MODE_SEL_BIT]) begin
        bank_d = BANK_W'(req_i.write_data & BANK_MASK);
      end else begin
        mode_d  = {mode_bits[7], mode_bits[2:0]};
        exrom_d = !mode_bits[1];
        game_d  = mode_bits[2] ? !mode_bits[0] : !jumper_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= '0;
      mode_q  <= '0;
      exrom_q <= 1'b1;
      game_q  <= 1'b0;
    end else begin
      bank_q  <= bank_d;
      mode_q  <= mode_d;
      exrom_q <= exrom_d;
      game_q  <= game_d;
    end
  end

  assign ctrl_o = '{bank: bank_q, mode: mode_q, exrom_n: exrom_q, game_n: game_q};

  // /EXROM follows the X bit of a mode write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    io1_wr && req_i.offset[MODE_SEL_BIT] |=> exrom_q == !$past(req_i.write_data[1]))
    else $error("exrom line does not follow mode write");

endmodule

>>> src/cbm_cart_ram.sv
module cbm_cart_ram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  logic [2:0]                cmd_i,
  input  logic [cbm_pkg::RAM_AW-1:0] addr_i,
  input  logic [7:0]                wdata_i,
  output logic [7:0]                rdata_o
);
  import cbm_pkg::*;

  logic [7:0]           mem [RAM_BYTES];
  logic [RAM_BYTES-1:0] vld_q;
  logic [7:0]           rd_q;
  logic                 rd_vld_q;
  logic                 wr_en;

  assign wr_en = acc_i && (cmd_i == CMD_IO2_WR);

  // storage and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (acc_i) begin
      rd_q <= mem[addr_i];
    end
  end

  // written-entry flags; unwritten bytes read as the preset fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (acc_i) begin
        rd_vld_q <= vld_q[addr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : RAM_FILL;

  // a written byte is marked valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> vld_q[$past(addr_i)])
    else $error("cart ram write not marked valid");

endmodule

>>> src/cbm_decode.sv
module cbm_decode (
  input  cbm_pkg::req_t  req_i,
  input  cbm_pkg::ctrl_t ctrl_i,
  input  logic [7:0]     ram_rd_i,
  output cbm_pkg::rsp_t  rsp_o
);
  import cbm_pkg::*;

  chip_e      chip;
  logic [7:0] data;
  logic       ex_act;
  logic       gm_act;

  assign ex_act = !ctrl_i.exrom_n;
  assign gm_act = !ctrl_i.game_n;

  // memory map by access type and line state
  always_comb begin
    chip = CHIP_NONE;
    data = '0;
    unique case (cmd_e'(req_i.cmd))
      CMD_ROML_RD: begin
        if (ex_act) begin
          if (req_i.lo_ram_line) chip = CHIP_LO;
          else data = req_i.sys_ram_data;
        end else if (gm_act) begin
          chip = CHIP_LO;
        end else begin
          data = req_i.sys_ram_data;
        end
      end
      CMD_ROMH_RD: begin
        if (gm_act && ex_act) begin
          if (req_i.hi_ram_line) chip = CHIP_HI;
          else data = req_i.sys_ram_data;
        end else if (gm_act) begin
          chip = CHIP_HI;
        end else begin
          data = req_i.lo_ram_line ? req_i.basic_rom_data : req_i.sys_ram_data;
        end
      end
      CMD_IO1_RD: begin
        data = req_i.open_bus_data;
      end
      CMD_IO2_RD: begin
        data = ram_rd_i;
      end
      default: begin
        chip = CHIP_NONE;
      end
    endcase
  end

  // flat flash address only when a chip is selected
  always_comb begin
    rsp_o.data_out = data;
    rsp_o.rom_chip = chip;
    rsp_o.rom_addr = (chip != CHIP_NONE) ? {BANK_TBL[ctrl_i.bank], req_i.offset} : '0;
    rsp_o.exrom_n  = ctrl_i.exrom_n;
    rsp_o.game_n   = ctrl_i.game_n;
    rsp_o.led_on   = ctrl_i.mode[MODE_W-1];
  end

endmodule

>>> test/cartridge_bank_mode_mapper_top_test.sv
module cartridge_bank_mode_mapper_top_test;
  import cbm_pkg::*;

  // unused access codes and io1 register selects
  localparam logic [2:0]          CMD_SPARE_6  = 3'd6;
  localparam logic [2:0]          CMD_SPARE_7  = 3'd7;
  localparam logic [OFFSET_W-1:0] SEL_BANK     = 13'h0000;
  localparam logic [OFFSET_W-1:0] SEL_BANK_ALT = 13'h1ffd;
  localparam logic [OFFSET_W-1:0] SEL_MODE     = 13'h0002;
  localparam logic [OFFSET_W-1:0] OFF_TOP      = 13'h1fff;

  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_COUNT  = 4;
  localparam int PHASE_ITEMS  = 125;
  localparam int SEND_IDLE_PCT [PHASE_COUNT] = '{0, 71, 0, 32};
  localparam int RECV_STALL_PCT[PHASE_COUNT] = '{0, 0, 71, 32};

  // mapper state mirror and pending bus replies
  class mapper_scoreboard;
    logic [BANK_W-1:0] bank;
    logic [MODE_W-1:0] mode;
    logic              exrom_n;
    logic              game_n;
    logic              jumper;
    logic [7:0]        cart_ram [RAM_BYTES];
    rsp_t              bus_replies[$];
    int                mismatches;

    function void reset_state();
      jumper  = 1'b1;
      bank    = '0;
      mode    = '0;
      exrom_n = 1'b1;
      game_n  = ~jumper;
      foreach (cart_ram[i]) cart_ram[i] = RAM_FILL;
      bus_replies.delete();
      mismatches = 0;
    endfunction

    function void set_jumper(logic v);
      jumper = v;
    endfunction

    // one bus access against the mirrored registers
    function rsp_t map_access(req_t a);
      rsp_t       r;
      logic [7:0] v;
      logic       ex_act;
      logic       gm_act;
      r      = '0;
      ex_act = ~exrom_n;
      gm_act = ~game_n;
      case (a.cmd)
        CMD_ROML_RD: begin
          if (ex_act) begin
            if (a.lo_ram_line) r.rom_chip = CHIP_LO;
            else r.data_out = a.sys_ram_data;
          end else if (gm_act) begin
            r.rom_chip = CHIP_LO;
          end else begin
            r.data_out = a.sys_ram_data;
          end
        end
        CMD_ROMH_RD: begin
          if (gm_act && ex_act) begin
            if (a.hi_ram_line) r.rom_chip = CHIP_HI;
            else r.data_out = a.sys_ram_data;
          end else if (gm_act) begin
            r.rom_chip = CHIP_HI;
          end else begin
            r.data_out = a.lo_ram_line ? a.basic_rom_data : a.sys_ram_data;
          end
        end
        CMD_IO1_RD: r.data_out = a.open_bus_data;
        CMD_IO1_WR: begin
          if (!a.offset[MODE_SEL_BIT]) begin
            bank = BANK_W'(a.write_data & BANK_MASK);
          end else begin
            v       = a.write_data & MODE_MASK;
            mode    = {v[7], v[2:0]};
            exrom_n = ~mode[1];
            game_n  = mode[2] ? ~mode[0] : ~jumper;
          end
        end
        CMD_IO2_RD: r.data_out = cart_ram[a.offset[RAM_AW-1:0]];
        CMD_IO2_WR: cart_ram[a.offset[RAM_AW-1:0]] = a.write_data;
        default: ;
      endcase
      if (r.rom_chip != CHIP_NONE) begin
        r.rom_addr = ROM_ADDR_W'((int'(bank) % BANK_COUNT) * BANK_BYTES + int'(a.offset));
      end
      r.exrom_n = exrom_n;
      r.game_n  = game_n;
      r.led_on  = mode[3];
      return r;
    endfunction

    function void note_access(req_t a);
      bus_replies.push_back(map_access(a));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (bus_replies.size() == 0) begin
        $error("result beat with no access pending");
        mismatches++;
        return;
      end
      want = bus_replies.pop_front();
      compare_field("data_out", 32'(want.data_out), 32'(got.data_out));
      compare_field("rom_chip", 32'(want.rom_chip), 32'(got.rom_chip));
      compare_field("rom_addr", 32'(want.rom_addr), 32'(got.rom_addr));
      compare_field("exrom_n", 32'(want.exrom_n), 32'(got.exrom_n));
      compare_field("game_n", 32'(want.game_n), 32'(got.game_n));
      compare_field("led_on", 32'(want.led_on), 32'(got.led_on));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   send_idle_pct;
  int   stall_pct;
  int   quiet_cycles;

  cbm_req_if req_bus();
  cbm_rsp_if rsp_bus();

  mapper_scoreboard sb = new;

  cartridge_bank_mode_mapper_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // random access with a realistic command mix
  function automatic req_t random_access();
    req_t        a;
    logic [63:0] r;
    int unsigned pick;
    r    = {$urandom, $urandom};
    a    = r[$bits(req_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 22) a.cmd = CMD_ROML_RD;
    else if (pick < 44) a.cmd = CMD_ROMH_RD;
    else if (pick < 50) a.cmd = CMD_IO1_RD;
    else if (pick < 70) a.cmd = CMD_IO1_WR;
    else if (pick < 83) a.cmd = CMD_IO2_RD;
    else if (pick < 95) a.cmd = CMD_IO2_WR;
    else a.cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
    // keep half of the ram traffic in a small window so reads hit written bytes
    if ((a.cmd == CMD_IO2_RD || a.cmd == CMD_IO2_WR) && $urandom_range(1)) begin
      a.offset[RAM_AW-1:0] = RAM_AW'($urandom_range(15));
    end
    return a;
  endfunction

  // directed access with random pass-through bytes
  function automatic req_t bus_access(logic [2:0] c, logic [OFFSET_W-1:0] off,
                                      logic [7:0] wd, logic lo, logic hi);
    req_t a;
    a             = random_access();
    a.cmd         = c;
    a.offset      = off;
    a.write_data  = wd;
    a.lo_ram_line = lo;
    a.hi_ram_line = hi;
    return a;
  endfunction

  // one beat on the request side, with random idle cycles ahead of it
  task automatic send_access(input req_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      req_bus.data  <= random_access();
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= a;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_access(a);
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.bus_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_jumper(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_jumper(v);
  endtask

  // result side: check accepted beats, stall at random
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid && rsp_bus.ready) sb.check_result(rsp_bus.data);
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
          quiet_cycles = 0;
        end else begin
          quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[cartridge_bank_mode_mapper_top] ERROR");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    send_idle_pct = 0;
    stall_pct     = 0;
    req_bus.valid = 1'b0;
    req_bus.data  = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b1;
    rst_n         = 1'b0;
    sb.reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: /game low, flash on both windows
    send_access(bus_access(CMD_ROML_RD, '0, 8'h00, 1'b0, 1'b0));
    send_access(bus_access(CMD_ROMH_RD, OFF_TOP, 8'h00, 1'b1, 1'b1));
    // cartridge ram preset, low byte addressing only
    send_access(bus_access(CMD_IO2_RD, '0, 8'h00, 1'b0, 1'b0));
    send_access(bus_access(CMD_IO2_WR, OFF_TOP, 8'ha5, 1'b1, 1'b0));
    send_access(bus_access(CMD_IO2_RD, 13'h00ff, 8'h00, 1'b0, 1'b1));
    send_access(bus_access(CMD_IO1_RD, '0, 8'h00, 1'b1, 1'b1));
    // top bank, top offset
    send_access(bus_access(CMD_IO1_WR, SEL_BANK_ALT, 8'hff, 1'b0, 1'b0));
    send_access(bus_access(CMD_ROML_RD, OFF_TOP, 8'h00, 1'b1, 1'b0));
    // all mode bits and led set
    send_access(bus_access(CMD_IO1_WR, SEL_MODE, 8'h87, 1'b0, 1'b0));
    send_access(bus_access(CMD_ROML_RD, 13'h0123, 8'h00, 1'b0, 1'b1));
    send_access(bus_access(CMD_ROML_RD, 13'h0123, 8'h00, 1'b1, 1'b0));
    send_access(bus_access(CMD_ROMH_RD, OFF_TOP, 8'h00, 1'b1, 1'b0));
    send_access(bus_access(CMD_ROMH_RD, OFF_TOP, 8'h00, 1'b0, 1'b1));
    // masked mode bits, then m set with g clear
    send_access(bus_access(CMD_IO1_WR, SEL_MODE, 8'h78, 1'b0, 1'b0));
    send_access(bus_access(CMD_IO1_WR, SEL_MODE, 8'h04, 1'b0, 1'b0));
    send_access(bus_access(CMD_ROML_RD, 13'h0042, 8'h00, 1'b1, 1'b1));
    send_access(bus_access(CMD_ROMH_RD, 13'h0042, 8'h00, 1'b1, 1'b1));
    send_access(bus_access(CMD_ROMH_RD, 13'h0042, 8'h00, 1'b0, 1'b1));
    // reserved modes
    send_access(bus_access(CMD_IO1_WR, SEL_MODE, 8'h01, 1'b0, 1'b0));
    send_access(bus_access(CMD_IO1_WR, SEL_MODE, 8'h03, 1'b0, 1'b0));
    send_access(bus_access(CMD_ROML_RD, 13'h0777, 8'h00, 1'b0, 1'b0));
    // unused codes
    send_access(bus_access(CMD_SPARE_6, OFF_TOP, 8'hff, 1'b1, 1'b1));
    send_access(bus_access(CMD_SPARE_7, '0, 8'h00, 1'b0, 1'b0));
    send_access(bus_access(CMD_IO1_WR, SEL_BANK, 8'h40, 1'b0, 1'b0));
    drain_results();

    // jumper to disable: no effect until the next mode write
    write_jumper(1'b0);
    send_access(bus_access(CMD_ROML_RD, 13'h0555, 8'h00, 1'b0, 1'b0));
    send_access(bus_access(CMD_IO1_WR, SEL_MODE, 8'h00, 1'b0, 1'b0));
    send_access(bus_access(CMD_ROMH_RD, 13'h0555, 8'h00, 1'b1, 1'b0));
    send_access(bus_access(CMD_IO1_WR, SEL_MODE, 8'h06, 1'b0, 1'b0));
    send_access(bus_access(CMD_ROML_RD, 13'h0aaa, 8'h00, 1'b1, 1'b1));
    send_access(bus_access(CMD_ROMH_RD, 13'h0aaa, 8'h00, 1'b0, 1'b1));
    drain_results();

    // random phases under each idling pattern and both jumper positions
    for (int p = 0; p < PHASE_COUNT; p++) begin
      send_idle_pct = SEND_IDLE_PCT[p];
      stall_pct     = RECV_STALL_PCT[p];
      write_jumper(p % 2 == 0);
      repeat (PHASE_ITEMS) send_access(random_access());
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.bus_replies.size() == 0) begin
      $display("[cartridge_bank_mode_mapper_top] OK");
    end else begin
      $display("[cartridge_bank_mode_mapper_top] ERROR");
    end
    $finish;
  end

endmodule
